[rtl/core/bsmp_pkg.sv]
// Package for the byte store mixing generator: microcode word type, field codes,
// configuration register indexes and the microcode table. No dependencies.
package bsmp_pkg;

  localparam int ADDR_W = 11;   // draw address and position width
  localparam int XW     = 12;   // modulo operand width, holds p + a
  localparam int DATA_W = 8;
  localparam int UPC_W  = 5;

  // configuration register indexes
  localparam logic CFG_STORE_SIZE = 1'b0;
  localparam logic CFG_START_POS  = 1'b1;

  // modulo operand select
  localparam logic [1:0] SRC_POS   = 2'd0;  // position pointer
  localparam logic [1:0] SRC_AXP   = 2'd1;  // a ^ p
  localparam logic [1:0] SRC_QOFS  = 2'd2;  // q + b, or q + a
  localparam logic [1:0] SRC_WADDR = 2'd3;  // a + p, or q

  // modulo result destination
  localparam logic [1:0] DST_P = 2'd0;
  localparam logic [1:0] DST_Q = 2'd1;
  localparam logic [1:0] DST_T = 2'd2;
  localparam logic [1:0] DST_W = 2'd3;

  // store read address select
  localparam logic [1:0] RD_P = 2'd0;
  localparam logic [1:0] RD_Q = 2'd1;
  localparam logic [1:0] RD_T = 2'd2;

  // store write kind
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_VW   = 3'd1;  // stirred byte at W
  localparam logic [2:0] WR_MIXP = 3'd2;  // xor mix at P
  localparam logic [2:0] WR_LOAD = 3'd3;
  localparam logic [2:0] WR_CLR  = 3'd4;

  // sequencing
  localparam logic [2:0] NXT_SEQ  = 3'd0;
  localparam logic [2:0] NXT_WAIT = 3'd1;  // hold while the modulo unit runs
  localparam logic [2:0] NXT_CLR  = 3'd2;  // loop until the clear sweep ends
  localparam logic [2:0] NXT_RET  = 3'd3;
  localparam logic [2:0] NXT_ACC  = 3'd4;  // dispatch on an accepted item

  // microcode addresses
  localparam logic [UPC_W-1:0] U_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] U_CLR  = 5'd1;
  localparam logic [UPC_W-1:0] U_LOAD = 5'd2;
  localparam logic [UPC_W-1:0] U_D0   = 5'd3;
  localparam logic [UPC_W-1:0] U_D1   = 5'd4;
  localparam logic [UPC_W-1:0] U_D2   = 5'd5;
  localparam logic [UPC_W-1:0] U_D3   = 5'd6;
  localparam logic [UPC_W-1:0] U_D4   = 5'd7;
  localparam logic [UPC_W-1:0] U_D5   = 5'd8;
  localparam logic [UPC_W-1:0] U_D6   = 5'd9;
  localparam logic [UPC_W-1:0] U_D7   = 5'd10;
  localparam logic [UPC_W-1:0] U_D8   = 5'd11;
  localparam logic [UPC_W-1:0] U_D9   = 5'd12;
  localparam logic [UPC_W-1:0] U_D10  = 5'd13;
  localparam logic [UPC_W-1:0] U_D11  = 5'd14;
  localparam logic [UPC_W-1:0] U_D12  = 5'd15;
  localparam logic [UPC_W-1:0] U_D13  = 5'd16;
  localparam logic [UPC_W-1:0] U_D14  = 5'd17;
  localparam logic [UPC_W-1:0] U_D15  = 5'd18;
  localparam logic [UPC_W-1:0] U_D16  = 5'd19;

  typedef struct packed {
    logic       mod_go;
    logic [1:0] mod_src;
    logic [1:0] mod_dst;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       lat_a;
    logic       lat_b;
    logic       lat_v;
    logic       emit;
    logic [2:0] wr_kind;
    logic [2:0] nxt;
  } uop_t;

  function automatic uop_t ucode(logic [UPC_W-1:0] upc);
    uop_t u;
    u = '0;
    case (upc)
      U_IDLE: u.nxt = NXT_ACC;
      U_CLR: begin
        u.wr_kind = WR_CLR;
        u.nxt     = NXT_CLR;
      end
      U_LOAD: begin
        u.wr_kind = WR_LOAD;
        u.nxt     = NXT_RET;
      end
      U_D0: begin
        u.mod_go  = 1'b1;
        u.mod_src = SRC_POS;
      end
      U_D1: begin
        u.mod_dst = DST_P;
        u.nxt     = NXT_WAIT;
      end
      U_D2: begin
        u.rd_en  = 1'b1;
        u.rd_sel = RD_P;
      end
      U_D3: u.lat_a = 1'b1;
      U_D4: begin
        u.mod_go  = 1'b1;
        u.mod_src = SRC_AXP;
      end
      U_D5: begin
        u.mod_dst = DST_Q;
        u.nxt     = NXT_WAIT;
      end
      U_D6: begin
        u.rd_en  = 1'b1;
        u.rd_sel = RD_Q;
      end
      U_D7: u.lat_b = 1'b1;
      U_D8: begin
        u.mod_go  = 1'b1;
        u.mod_src = SRC_QOFS;
        u.emit    = 1'b1;
      end
      U_D9: begin
        u.mod_dst = DST_T;
        u.nxt     = NXT_WAIT;
      end
      U_D10: begin
        u.rd_en  = 1'b1;
        u.rd_sel = RD_T;
      end
      U_D11: u.lat_v = 1'b1;
      U_D12: begin
        u.mod_go  = 1'b1;
        u.mod_src = SRC_WADDR;
      end
      U_D13: begin
        u.mod_dst = DST_W;
        u.nxt     = NXT_WAIT;
      end
      U_D14: u.wr_kind = WR_VW;
      U_D15: begin
        u.rd_en  = 1'b1;
        u.rd_sel = RD_P;
      end
      U_D16: begin
        u.wr_kind = WR_MIXP;
        u.nxt     = NXT_RET;
      end
      default: u.nxt = NXT_RET;
    endcase
    return u;
  endfunction

endpackage

[rtl/core/byte_store_mixing_prng.sv]
// Byte store mixing random generator: microcoded sequencer, byte store memory
// and a bit-serial modulo unit. Depends on bsmp_pkg.
//
// channel   ports                                          handshake
// input     in_req_type, in_load_address, in_load_data     start & !busy
// result    out_random_byte                                out_valid, one cycle
// config    cfg_index, cfg_wdata                           cfg_we
//
// Busy stays high after a load or draw transfer until the item's microcode
// sequence returns to idle, so no new item is taken while one is in work; the
// result strobe is registered from the draw's emit step. The draw time is set
// by four address reductions in the shared modulo unit (one quotient bit per
// cycle) and the store reads and writes, which the microcode makes in turn.
// After reset a clearing pass zeroes the store with busy high; configuration
// writes are taken throughout. The receiver cannot stall.
module byte_store_mixing_prng #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [9:0]  in_load_address,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  output logic [7:0]  out_random_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);
  import bsmp_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_W = 17'(STORE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);
  localparam logic [3:0] MOD_STEPS = 4'(XW);

  logic [UPC_W-1:0]  upc_r, upc_nxt;
  uop_t              u;
  logic [ADDR_W-1:0] size_r, pos_r, sz_eff;
  logic [ADDR_W-1:0] p_r, q_r, t_r, w_r;
  logic [7:0]        a_r, b_r, v_r, rd_q, res;
  logic [9:0]        ld_addr_r;
  logic [7:0]        ld_data_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              le;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;

  logic [XW-1:0]     mod_x_r, mod_src_val, mod_rem_sh;
  logic [ADDR_W-1:0] mod_rem_r;
  logic [3:0]        mod_cnt_r;
  logic              mod_busy_r, mod_ge;

  logic [7:0]        mem [STORE_DEPTH];
  logic              wr_en;
  logic [AW-1:0]     wr_idx, rd_idx;
  logic [7:0]        wr_data, mix_val, stir_val;

  assign u         = ucode(upc_r);
  assign busy      = (upc_r != U_IDLE);
  assign out_valid = out_valid_r;
  assign out_random_byte = out_byte_r;

  assign res = a_r + b_r;
  assign le  = (a_r <= b_r);

  always_comb begin
    if (size_r == '0) begin
      sz_eff = 11'd1;
    end else if ({6'd0, size_r} > DEPTH_W) begin
      sz_eff = 11'(STORE_DEPTH);
    end else begin
      sz_eff = size_r;
    end
  end

  // operand for the modulo unit
  always_comb begin
    case (u.mod_src)
      SRC_POS:  mod_src_val = {1'b0, pos_r};
      SRC_AXP:  mod_src_val = {1'b0, p_r ^ {3'd0, a_r}};
      SRC_QOFS: mod_src_val = {1'b0, q_r} + {4'd0, (le ? b_r : a_r)};
      SRC_WADDR: mod_src_val = le ? ({1'b0, p_r} + {4'd0, a_r}) : {1'b0, q_r};
      default:  mod_src_val = '0;
    endcase
  end

  // restoring remainder, one dividend bit per cycle
  assign mod_rem_sh = {mod_rem_r, mod_x_r[XW-1]};
  assign mod_ge     = (mod_rem_sh >= {1'b0, sz_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
    end else if (u.mod_go) begin
      mod_x_r    <= mod_src_val;
      mod_rem_r  <= '0;
      mod_cnt_r  <= MOD_STEPS;
      mod_busy_r <= 1'b1;
    end else if (mod_busy_r) begin
      mod_x_r   <= {mod_x_r[XW-2:0], 1'b0};
      mod_rem_r <= mod_ge ? ADDR_W'(mod_rem_sh - {1'b0, sz_eff})
                          : mod_rem_sh[ADDR_W-1:0];
      mod_cnt_r <= mod_cnt_r - 4'd1;
      if (mod_cnt_r == 4'd1) begin
        mod_busy_r <= 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    upc_nxt = upc_r + 5'd1;
    case (u.nxt)
      NXT_SEQ:  upc_nxt = upc_r + 5'd1;
      NXT_WAIT: upc_nxt = mod_busy_r ? upc_r : upc_r + 5'd1;
      NXT_CLR:  upc_nxt = (clr_cnt_r == CLR_LAST) ? U_IDLE : upc_r;
      NXT_RET:  upc_nxt = U_IDLE;
      NXT_ACC: begin
        if (start) begin
          upc_nxt = in_req_type ? U_D0 : U_LOAD;
        end else begin
          upc_nxt = U_IDLE;
        end
      end
      default:  upc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r     <= U_CLR;
      clr_cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      if (u.wr_kind == WR_CLR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // configuration and position pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 11'd1024;
      pos_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STORE_SIZE: size_r <= cfg_wdata;
          CFG_START_POS:  pos_r  <= {1'b0, cfg_wdata[9:0]};
          default: ;
        endcase
      end
      // advance past the drawn position
      if (u.wr_kind == WR_MIXP) begin
        pos_r <= p_r + 11'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (u.nxt == NXT_ACC && start) begin
      ld_addr_r <= in_load_address;
      ld_data_r <= in_load_data;
    end
    if (u.nxt == NXT_WAIT && !mod_busy_r) begin
      case (u.mod_dst)
        DST_P:   p_r <= mod_rem_r;
        DST_Q:   q_r <= mod_rem_r;
        DST_T:   t_r <= mod_rem_r;
        DST_W:   w_r <= mod_rem_r;
        default: ;
      endcase
    end
    if (u.lat_a) a_r <= rd_q;
    if (u.lat_b) b_r <= rd_q;
    if (u.lat_v) v_r <= stir_val;
    if (u.emit)  out_byte_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= u.emit;
    end
  end

  // a stirred or mixed zero is stored as one
  always_comb begin
    stir_val = rd_q + (le ? a_r : res);
    if (stir_val == 8'd0) stir_val = 8'd1;
    mix_val = rd_q ^ (le ? res : b_r);
    if (mix_val == 8'd0) mix_val = 8'd1;
  end

  // store port
  always_comb begin
    case (u.rd_sel)
      RD_P:    rd_idx = AW'(p_r);
      RD_Q:    rd_idx = AW'(q_r);
      RD_T:    rd_idx = AW'(t_r);
      default: rd_idx = AW'(p_r);
    endcase
    wr_en   = 1'b0;
    wr_idx  = clr_cnt_r;
    wr_data = 8'd0;
    case (u.wr_kind)
      WR_VW: begin
        wr_en   = rst_n;
        wr_idx  = AW'(w_r);
        wr_data = v_r;
      end
      WR_MIXP: begin
        wr_en   = rst_n;
        wr_idx  = AW'(p_r);
        wr_data = mix_val;
      end
      WR_LOAD: begin
        // drop loads beyond the store depth
        wr_en   = rst_n && ({7'd0, ld_addr_r} < DEPTH_W);
        wr_idx  = AW'(ld_addr_r);
        wr_data = ld_data_r;
      end
      WR_CLR: begin
        wr_en   = rst_n;
        wr_idx  = clr_cnt_r;
        wr_data = 8'd0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (u.rd_en) rd_q <= mem[rd_idx];
  end

  a_result_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a draw");

  a_mod_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    u.mod_go |-> !mod_busy_r)
    else $error("modulo unit restarted while running");

  a_pos_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_D2) |-> (p_r < sz_eff))
    else $error("draw position not reduced below store size");

  a_q_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_D6) |-> (q_r < sz_eff))
    else $error("partner address not reduced below store size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

endmodule
